// ===== hdl/id3x_pkg.sv =====
// Shared types, codes and constants of the ID3v2 picture frame extractor.
`default_nettype none
package id3x_pkg;

   localparam int unsigned TAG_SIZE_W = 28;
   localparam logic [TAG_SIZE_W-1:0] DEFAULT_MAX_TAG = 28'd67108864;
   localparam logic [31:0] HDR_LEN = 32'd10;
   localparam logic [31:0] APIC_ID = 32'h41504943;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [3:0] PH_HDR     = 4'd0;
   localparam logic [3:0] PH_EXT     = 4'd1;
   localparam logic [3:0] PH_EXTSKIP = 4'd2;
   localparam logic [3:0] PH_FHDR    = 4'd3;
   localparam logic [3:0] PH_FSKIP   = 4'd4;
   localparam logic [3:0] PH_ENC     = 4'd5;
   localparam logic [3:0] PH_MIME    = 4'd6;
   localparam logic [3:0] PH_PTYPE   = 4'd7;
   localparam logic [3:0] PH_DESC    = 4'd8;
   localparam logic [3:0] PH_IMAGE   = 4'd9;
   localparam logic [3:0] PH_DRAIN   = 4'd10;
   localparam logic [3:0] PH_DONE    = 4'd11;

   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_NOTTAG  = 3'd1;
   localparam logic [2:0] ST_BADSIZE = 3'd2;
   localparam logic [2:0] ST_TRUNC   = 3'd3;
   localparam logic [2:0] ST_NOPIC   = 3'd4;

   localparam logic [0:0] REG_MAX_TAG_SIZE = 1'd0;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic       is_report;
      logic [7:0] image_byte;
      logic [2:0] status;
      logic       run_last;
   } rsp_type;

   // what the parser decided for one byte
   typedef struct packed {
      logic       img;
      logic       eos;
      logic [7:0] data;
      logic [2:0] status;
   } work_type;

endpackage
`default_nettype wire

// ===== hdl/id3x_parser.sv =====
// Front end: per-byte tag parser that classifies each byte.
`default_nettype none
module id3x_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire id3x_pkg::req_type      req,
   input  wire logic [id3x_pkg::TAG_SIZE_W-1:0] max_tag_size,
   output id3x_pkg::work_type          work
);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  fc_ff, fc_in;
   logic [2:0]  ver_ff, ver_in;
   logic        extp_ff, extp_in;
   logic [27:0] tsz_ff, tsz_in;
   logic [31:0] esz_ff, esz_in;
   logic [31:0] skip_ff, skip_in;
   logic [27:0] bpos_ff, bpos_in;
   logic [27:0] blen_ff, blen_in;
   logic [31:0] fid_ff, fid_in;
   logic [31:0] fsz_ff, fsz_in;
   logic [31:0] foff_ff, foff_in;
   logic [7:0]  enc_ff, enc_in;
   logic [1:0]  pair_ff, pair_in;
   logic [2:0]  out_ff, out_in;

   logic [7:0]  b;
   logic [31:0] esz_sh, fsz_sh, foff_nx;
   logic [28:0] remain_nx;
   logic        fend, img;
   logic [3:0]  after_start;

   // frame scan starts only if a whole header fits in the body
   function automatic logic [3:0] PH_FHDR_or_drain(input logic [27:0] len);
      return (len < 28'd10) ? id3x_pkg::PH_DRAIN : id3x_pkg::PH_FHDR;
   endfunction

   assign b = req.byte_in;
   assign esz_sh = (ver_ff == 3'd4) ? {esz_ff[24:0], b[6:0]} : {esz_ff[23:0], b};
   assign fsz_sh = (ver_ff == 3'd4) ? {fsz_ff[24:0], b[6:0]} : {fsz_ff[23:0], b};
   assign foff_nx = foff_ff + 32'd1;
   assign fend = foff_nx >= fsz_ff;

   always_comb begin
      phase_in = phase_ff; fc_in = fc_ff; ver_in = ver_ff; extp_in = extp_ff;
      tsz_in = tsz_ff; esz_in = esz_ff; skip_in = skip_ff; bpos_in = bpos_ff;
      blen_in = blen_ff; fid_in = fid_ff; fsz_in = fsz_ff; foff_in = foff_ff;
      enc_in = enc_ff; pair_in = pair_ff; out_in = out_ff;
      img = 1'b0;
      remain_nx = 29'd0;
      after_start = PH_FHDR_or_drain(blen_in);
      unique case (phase_ff)
         id3x_pkg::PH_HDR: begin
            if ((fc_ff == 4'd0 && b != 8'h49) || (fc_ff == 4'd1 && b != 8'h44) ||
                (fc_ff == 4'd2 && b != 8'h33) ||
                (fc_ff == 4'd3 && (b < 8'd2 || b > 8'd4))) begin
               out_in = id3x_pkg::ST_NOTTAG; phase_in = id3x_pkg::PH_DONE;
            end else begin
               if (fc_ff == 4'd3) ver_in = b[2:0];
               if (fc_ff == 4'd5) extp_in = b[6];
               if (fc_ff >= 4'd6) tsz_in = {tsz_ff[20:0], b[6:0]};
               if (fc_ff < 4'd9) fc_in = fc_ff + 4'd1;
               else if (tsz_in == 28'd0 || tsz_in > max_tag_size) begin
                  out_in = id3x_pkg::ST_BADSIZE; phase_in = id3x_pkg::PH_DONE;
               end else if (extp_ff) begin
                  phase_in = id3x_pkg::PH_EXT; fc_in = 4'd0; esz_in = 32'd0;
               end else begin
                  blen_in = tsz_in; bpos_in = 28'd0;
                  phase_in = PH_FHDR_or_drain(tsz_in);
                  fc_in = 4'd0; fid_in = 32'd0; fsz_in = 32'd0;
               end
            end
         end
         id3x_pkg::PH_EXT: begin
            esz_in = esz_sh;
            if (fc_ff < 4'd3) fc_in = fc_ff + 4'd1;
            else if (esz_sh > {4'd0, tsz_ff} || esz_sh[27:0] == tsz_ff) begin
               out_in = id3x_pkg::ST_BADSIZE; phase_in = id3x_pkg::PH_DONE;
            end else begin
               blen_in = tsz_ff - esz_sh[27:0];
               if (esz_sh > 32'd4) begin
                  skip_in = esz_sh - 32'd4; phase_in = id3x_pkg::PH_EXTSKIP;
               end else begin
                  bpos_in = 28'd0; phase_in = PH_FHDR_or_drain(blen_in);
                  fc_in = 4'd0; fid_in = 32'd0; fsz_in = 32'd0;
               end
            end
         end
         id3x_pkg::PH_EXTSKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_in == 32'd0) begin
               bpos_in = 28'd0; phase_in = after_start;
               fc_in = 4'd0; fid_in = 32'd0; fsz_in = 32'd0;
            end
         end
         id3x_pkg::PH_DONE: begin
         end
         id3x_pkg::PH_FHDR, id3x_pkg::PH_FSKIP, id3x_pkg::PH_ENC, id3x_pkg::PH_MIME,
         id3x_pkg::PH_PTYPE, id3x_pkg::PH_DESC, id3x_pkg::PH_IMAGE,
         id3x_pkg::PH_DRAIN: begin
            bpos_in = bpos_ff + 28'd1;
            remain_nx = {1'b0, blen_ff} - {1'b0, bpos_in};
            if (phase_ff == id3x_pkg::PH_FHDR) begin
               if (fc_ff < 4'd4) fid_in = {fid_ff[23:0], b};
               else if (fc_ff < 4'd8) fsz_in = fsz_sh;
               if (fc_ff < 4'd9) fc_in = fc_ff + 4'd1;
               else if (fid_ff == 32'd0 || fsz_ff == 32'd0 ||
                        fsz_ff > {3'd0, remain_nx}) begin
                  phase_in = id3x_pkg::PH_DRAIN;
               end else begin
                  foff_in = 32'd0;
                  phase_in = (fid_ff == id3x_pkg::APIC_ID) ? id3x_pkg::PH_ENC
                                                          : id3x_pkg::PH_FSKIP;
               end
            end else if (phase_ff != id3x_pkg::PH_DRAIN) begin
               foff_in = foff_nx;
               if (phase_ff == id3x_pkg::PH_FSKIP) begin
                  if (fend) begin
                     if (remain_nx < 29'd10) phase_in = id3x_pkg::PH_DRAIN;
                     else begin
                        phase_in = id3x_pkg::PH_FHDR; fc_in = 4'd0;
                        fid_in = 32'd0; fsz_in = 32'd0;
                     end
                  end
               end else if (phase_ff == id3x_pkg::PH_DESC && !fend &&
                            (((enc_ff == 8'd0 || enc_ff == 8'd3) && b == 8'd0) ||
                             (enc_ff != 8'd0 && enc_ff != 8'd3 && pair_ff == 2'd1 &&
                              b == 8'd0))) begin
                  phase_in = id3x_pkg::PH_IMAGE; out_in = id3x_pkg::ST_FOUND;
               end else begin
                  if (phase_ff == id3x_pkg::PH_ENC) begin
                     enc_in = b; phase_in = id3x_pkg::PH_MIME;
                  end
                  if (phase_ff == id3x_pkg::PH_MIME && b == 8'd0)
                     phase_in = id3x_pkg::PH_PTYPE;
                  if (phase_ff == id3x_pkg::PH_PTYPE) begin
                     phase_in = id3x_pkg::PH_DESC; pair_in = 2'd0;
                  end
                  if (phase_ff == id3x_pkg::PH_DESC && enc_ff != 8'd0 &&
                      enc_ff != 8'd3)
                     pair_in = (pair_ff == 2'd0) ? ((b == 8'd0) ? 2'd1 : 2'd2) : 2'd0;
                  if (phase_ff == id3x_pkg::PH_IMAGE) img = 1'b1;
                  if (fend) phase_in = id3x_pkg::PH_DRAIN;
               end
            end
            if (bpos_in >= blen_ff) phase_in = id3x_pkg::PH_DONE;
         end
         default: phase_in = id3x_pkg::PH_DONE;
      endcase
   end

   assign work.img = img;
   assign work.eos = req.end_of_stream;
   assign work.data = b;
   assign work.status = (phase_in == id3x_pkg::PH_DONE) ? out_in : id3x_pkg::ST_TRUNC;

   always_ff @(posedge clock) begin
      if (reset || (take && req.end_of_stream)) begin
         phase_ff <= id3x_pkg::PH_HDR; fc_ff <= '0; ver_ff <= '0; extp_ff <= 1'b0;
         tsz_ff <= '0; esz_ff <= '0; skip_ff <= '0; bpos_ff <= '0; blen_ff <= '0;
         fid_ff <= '0; fsz_ff <= '0; foff_ff <= '0; enc_ff <= '0; pair_ff <= '0;
         out_ff <= id3x_pkg::ST_NOPIC;
      end else if (take) begin
         phase_ff <= phase_in; fc_ff <= fc_in; ver_ff <= ver_in; extp_ff <= extp_in;
         tsz_ff <= tsz_in; esz_ff <= esz_in; skip_ff <= skip_in; bpos_ff <= bpos_in;
         blen_ff <= blen_in; fid_ff <= fid_in; fsz_ff <= fsz_in; foff_ff <= foff_in;
         enc_ff <= enc_in; pair_ff <= pair_in; out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      take && req.end_of_stream |=> phase_ff == id3x_pkg::PH_HDR && fc_ff == 4'd0)
      else $error("parser not rearmed after end of stream");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff >= id3x_pkg::PH_FHDR && phase_ff <= id3x_pkg::PH_DRAIN |->
      bpos_ff < blen_ff)
      else $error("body position past body length");
   a_img: assert property (@(posedge clock) disable iff (reset)
      work.img |-> phase_ff == id3x_pkg::PH_IMAGE)
      else $error("image byte outside image phase");
`endif

endmodule
`default_nettype wire

// ===== hdl/id3x_emitter.sv =====
// Back end: queue of classified words and output stage that expands them.
`default_nettype none
module id3x_emitter #(
   parameter int unsigned DEPTH = id3x_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire id3x_pkg::work_type work,
   output logic                    space,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output id3x_pkg::rsp_type       rsp_payload
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   id3x_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          half_ff, half_in; // image part of an image+report word already sent
   logic          pop, has, keep;
   id3x_pkg::work_type head;

   assign keep = push && (work.img || work.eos);
   assign space = cnt_ff < (AW+1)'(DEPTH);
   assign has = cnt_ff != '0;
   assign head = mem_ff[rp_ff];

   always_comb begin
      rsp_valid = has;
      rsp_payload = '0;
      if (head.img && !half_ff) begin
         rsp_payload.image_byte = head.data;
         rsp_payload.run_last = !head.eos;
      end else begin
         rsp_payload.is_report = 1'b1;
         rsp_payload.status = head.status;
         rsp_payload.run_last = 1'b1;
      end
   end

   always_comb begin
      pop = 1'b0; half_in = half_ff;
      if (has && rsp_ready) begin
         if (head.img && head.eos && !half_ff) half_in = 1'b1;
         else begin
            pop = 1'b1; half_in = 1'b0;
         end
      end
      wp_in = keep ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1)) : wp_ff;
      rp_in = pop ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1)) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(keep) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in; half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) mem_ff[wp_ff] <= work;
   end

`ifndef SYNTHESIS
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      keep |-> space)
      else $error("queue overflow");
   a_half: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> has && head.img && head.eos)
      else $error("split word state lost");
`endif

endmodule
`default_nettype wire

// ===== hdl/id3v2_picture_frame_extractor.sv =====
// Top level of the ID3v2 attached-picture extractor.
//
//  channel  direction  handshake            word
//  req_     in         req_valid/req_ready  byte_in, end_of_stream
//  rsp_     out        rsp_valid/rsp_ready  is_report, image_byte, status, run_last
//  csr_     in         APB write/read       max_tag_size at byte address 0
//
// One byte is taken per cycle while the queue has room; the parser decides in the cycle it accepts.
// Only image bytes and end-of-stream words go through a small queue; an image byte
// that ends the stream is sent as an image word, then a report.
// req_ready drops only when the queue is full; the queue absorbs output stalls.
// Reset is synchronous: parser rearms and max_tag_size returns to 64 MiB.
`default_nettype none
module id3v2_picture_frame_extractor #(
   parameter int unsigned QUEUE_DEPTH = id3x_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire id3x_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output id3x_pkg::rsp_type      rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [1:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [id3x_pkg::TAG_SIZE_W-1:0] max_ff;
   logic take;
   id3x_pkg::work_type work;

   // accept a byte whenever the queue has room
   assign take = req_valid && req_ready;
   assign pready = 1'b1;
   assign prdata = {4'd0, max_ff};

   // hold the cap; only register index 0 exists, written at byte address 0
   always_ff @(posedge clock) begin
      if (reset) max_ff <= id3x_pkg::DEFAULT_MAX_TAG;
      else if (psel && penable && pwrite &&
               paddr == 2'({id3x_pkg::REG_MAX_TAG_SIZE, 2'b00}))
         max_ff <= pwdata[id3x_pkg::TAG_SIZE_W-1:0];
   end

   id3x_parser u_parser (
      .clock(clock), .reset(reset), .take(take), .req(req_payload),
      .max_tag_size(max_ff), .work(work)
   );

   id3x_emitter #(.DEPTH(QUEUE_DEPTH)) u_emitter (
      .clock(clock), .reset(reset), .push(take), .work(work), .space(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

`ifndef SYNTHESIS
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr == 2'({id3x_pkg::REG_MAX_TAG_SIZE, 2'b00})
      |=> max_ff == $past(pwdata[27:0]))
      else $error("cap register not written");
   a_rpt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_report |-> rsp_payload.run_last)
      else $error("report not last");
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_report |-> rsp_payload.status <= id3x_pkg::ST_NOPIC)
      else $error("bad status code");
`endif

endmodule
`default_nettype wire

// ===== test/id3v2_picture_frame_extractor_test.sv =====
// Self-checking testbench of the ID3v2 attached-picture extractor.
`default_nettype none
module id3v2_picture_frame_extractor_test;

   // ---------------------------------------------------------------------
   // Clock, reset and the ports of the block
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   logic              req_valid = 1'b0;
   logic              req_ready;
   id3x_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   id3x_pkg::rsp_type rsp_payload;
   logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   id3v2_picture_frame_extractor i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // ---------------------------------------------------------------------
   // Parser mirror: tracks the tag, frame and description state per byte
   // ---------------------------------------------------------------------
   logic [27:0] cap_size;
   logic [3:0]  ph;
   logic [3:0]  fcount;
   logic [2:0]  ver;
   logic        has_ext;
   logic [27:0] tsize;
   logic [31:0] esize, eskip;
   logic [27:0] bpos, blen;
   logic [31:0] fid, fsize, foff;
   logic [7:0]  enc;
   logic [1:0]  pairs;
   logic [2:0]  verdict;

   id3x_pkg::rsp_type expected_words[$];
   int      mismatches = 0;
   int      words_seen = 0;
   int      reports_seen = 0;
   int      images_seen = 0;
   int      bytes_sent = 0;

   function automatic void rearm_parser();
      ph = id3x_pkg::PH_HDR; fcount = 0; ver = 0; has_ext = 0; tsize = 0; esize = 0;
      eskip = 0; bpos = 0; blen = 0; fid = 0; fsize = 0; foff = 0; enc = 0;
      pairs = 0; verdict = id3x_pkg::ST_NOPIC;
   endfunction

   function automatic void give_up(logic [2:0] code);
      verdict = code;
      ph = id3x_pkg::PH_DONE;
   endfunction

   function automatic void seek_frame();
      if ({4'd0, blen} - {4'd0, bpos} < id3x_pkg::HDR_LEN) begin
         ph = id3x_pkg::PH_DRAIN;
      end else begin
         ph = id3x_pkg::PH_FHDR; fcount = 0; fid = 0; fsize = 0;
      end
   endfunction

   function automatic logic [31:0] grow_size(logic [31:0] acc, logic [7:0] b);
      if (ver == 3'd4) begin
         return (acc << 7) | {25'd0, b[6:0]};
      end
      return (acc << 8) | {24'd0, b};
   endfunction

   // tag header: magic, version, flags and synchsafe size
   function automatic void take_header(logic [7:0] b);
      if ((fcount == 0 && b != 8'h49) || (fcount == 1 && b != 8'h44) ||
          (fcount == 2 && b != 8'h33) || (fcount == 3 && (b < 2 || b > 4))) begin
         give_up(id3x_pkg::ST_NOTTAG);
         return;
      end
      if (fcount == 3) ver = b[2:0];
      if (fcount == 5) has_ext = b[6];
      if (fcount >= 6) tsize = {tsize[20:0], b[6:0]};
      if (fcount < 9) begin
         fcount++;
         return;
      end
      if (tsize == 0 || tsize > cap_size) begin
         give_up(id3x_pkg::ST_BADSIZE);
         return;
      end
      if (has_ext) begin
         ph = id3x_pkg::PH_EXT; fcount = 0; esize = 0;
      end else begin
         blen = tsize; bpos = 0; seek_frame();
      end
   endfunction

   function automatic void take_ext(logic [7:0] b);
      esize = grow_size(esize, b);
      if (fcount < 3) begin
         fcount++;
         return;
      end
      if (esize > {4'd0, tsize}) begin
         give_up(id3x_pkg::ST_BADSIZE);
         return;
      end
      blen = tsize - esize[27:0];
      if (blen == 0) begin
         give_up(id3x_pkg::ST_BADSIZE);
         return;
      end
      eskip = (esize > 4) ? esize - 4 : 0;
      if (eskip != 0) begin
         ph = id3x_pkg::PH_EXTSKIP;
      end else begin
         bpos = 0; seek_frame();
      end
   endfunction

   // one byte inside the tag body; returns 1 for an image byte
   function automatic logic take_body(logic [7:0] b);
      logic fend;
      logic img;
      img = 1'b0;
      bpos++;
      if (ph == id3x_pkg::PH_FHDR) begin
         if (fcount < 4) fid = {fid[23:0], b};
         else if (fcount < 8) fsize = grow_size(fsize, b);
         if (fcount < 9) begin
            fcount++;
         end else if (fid == 0 || fsize == 0 ||
                      {4'd0, fsize} > {8'd0, blen} - {8'd0, bpos}) begin
            ph = id3x_pkg::PH_DRAIN;
         end else begin
            foff = 0;
            ph = (fid == id3x_pkg::APIC_ID) ? id3x_pkg::PH_ENC : id3x_pkg::PH_FSKIP;
         end
         return 1'b0;
      end
      if (ph == id3x_pkg::PH_DRAIN) return 1'b0;
      foff++;
      fend = (foff >= fsize);
      case (ph)
         id3x_pkg::PH_FSKIP: begin
            if (fend) seek_frame();
            return 1'b0;
         end
         id3x_pkg::PH_ENC: begin
            enc = b; ph = id3x_pkg::PH_MIME;
         end
         id3x_pkg::PH_MIME: begin
            if (b == 0) ph = id3x_pkg::PH_PTYPE;
         end
         id3x_pkg::PH_PTYPE: begin
            ph = id3x_pkg::PH_DESC; pairs = 0;
         end
         id3x_pkg::PH_DESC: begin
            if (enc == 0 || enc == 3) begin
               if (b == 0 && !fend) begin
                  ph = id3x_pkg::PH_IMAGE; verdict = id3x_pkg::ST_FOUND;
                  return 1'b0;
               end
            end else if (pairs == 0) begin
               pairs = (b == 0) ? 2'd1 : 2'd2;
            end else begin
               if (pairs == 1 && b == 0 && !fend) begin
                  ph = id3x_pkg::PH_IMAGE; verdict = id3x_pkg::ST_FOUND;
                  return 1'b0;
               end
               pairs = 0;
            end
         end
         id3x_pkg::PH_IMAGE: img = 1'b1;
         default: ;
      endcase
      if (fend) ph = id3x_pkg::PH_DRAIN;
      return img;
   endfunction

   // predict the words of one accepted byte and queue them
   function automatic void predict_words(id3x_pkg::req_type w);
      logic              img;
      id3x_pkg::rsp_type r;
      img = 1'b0;
      case (ph)
         id3x_pkg::PH_HDR:  take_header(w.byte_in);
         id3x_pkg::PH_EXT:  take_ext(w.byte_in);
         id3x_pkg::PH_EXTSKIP: begin
            eskip--;
            if (eskip == 0) begin
               bpos = 0; seek_frame();
            end
         end
         id3x_pkg::PH_DONE: ;
         default: begin
            img = take_body(w.byte_in);
            if (bpos >= blen) ph = id3x_pkg::PH_DONE;
         end
      endcase
      if (img) begin
         r = '{is_report: 1'b0, image_byte: w.byte_in, status: id3x_pkg::ST_FOUND,
               run_last: !w.end_of_stream};
         expected_words.push_back(r);
      end
      if (w.end_of_stream) begin
         r = '{is_report: 1'b1, image_byte: 8'd0,
               status: (ph == id3x_pkg::PH_DONE) ? verdict : id3x_pkg::ST_TRUNC,
               run_last: 1'b1};
         expected_words.push_back(r);
         rearm_parser();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Idling knobs and the long receiver hold-off
   // ---------------------------------------------------------------------
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;

   // receiver: stall at random, or hold for a counted stretch when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // checker: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      id3x_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (rsp_payload.is_report) reports_seen++;
         else images_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_payload);
         end else begin
            want = expected_words.pop_front();
            if (rsp_payload !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"word %0d: expected rep=%b byte=%h st=%0d last=%b, ",
                            "got rep=%b byte=%h st=%0d last=%b"},
                           words_seen, want.is_report, want.image_byte, want.status,
                           want.run_last, rsp_payload.is_report, rsp_payload.image_byte,
                           rsp_payload.status, rsp_payload.run_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender and register helpers
   // ---------------------------------------------------------------------
   // valid stays up after a byte; the next idle cycle or a drain drops it
   task automatic send_byte(logic [7:0] b, logic eos);
      id3x_pkg::req_type w;
      w = '{byte_in: b, end_of_stream: eos};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_words(w);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_cap(logic [27:0] v);
      logic [31:0] got;
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 2'({id3x_pkg::REG_MAX_TAG_SIZE, 2'b00});
      pwdata <= {4'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      // read it back: psel stays up, this cycle is the read setup
      penable <= 1'b0; pwrite <= 1'b0;
      cap_size = v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (got[27:0] !== v) begin
         mismatches++;
         if (mismatches <= 10) $display("register readback %h, wrote %h", got, v);
      end
   endtask

   // byte stream of one tag under construction
   logic [7:0] stream[$];

   function automatic void put_synchsafe(int unsigned v);
      stream.push_back({1'b0, v[27:21]});
      stream.push_back({1'b0, v[20:14]});
      stream.push_back({1'b0, v[13:7]});
      stream.push_back({1'b0, v[6:0]});
   endfunction

   function automatic void put_size(int unsigned v, int unsigned version);
      if (version == 4) put_synchsafe(v);
      else begin
         stream.push_back(v[31:24]); stream.push_back(v[23:16]);
         stream.push_back(v[15:8]);  stream.push_back(v[7:0]);
      end
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   // build a random, mostly well-formed tag with an optional picture frame
   function automatic void build_tag();
      int unsigned version, body, fsz, i, n, enc_v;
      logic [7:0]  body_bytes[$];
      logic        ext;
      version = $urandom_range(4, 2);
      ext = ($urandom_range(3) == 0);
      stream.delete();
      // frames: maybe one other frame, then usually an APIC frame
      if ($urandom_range(2) == 0) begin
         fsz = $urandom_range(6, 1);
         body_bytes.push_back("T"); body_bytes.push_back("I");
         body_bytes.push_back("T"); body_bytes.push_back("2");
         for (i = 0; i < 4; i++) body_bytes.push_back(8'd0);
         body_bytes[4 + 3] = fsz[7:0];
         body_bytes.push_back(8'd0); body_bytes.push_back(8'd0);
         for (i = 0; i < fsz; i++) body_bytes.push_back(any_byte());
      end
      if ($urandom_range(5) != 0) begin
         logic [7:0] content[$];
         enc_v = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
         content.push_back(enc_v[7:0]);
         n = $urandom_range(4);
         for (i = 0; i < n; i++) content.push_back(8'($urandom_range(255, 1)));
         if ($urandom_range(9) != 0) content.push_back(8'd0);
         content.push_back(any_byte());
         n = $urandom_range(3);
         for (i = 0; i < n; i++)
            content.push_back(($urandom_range(3) == 0) ? 8'd0 : any_byte());
         content.push_back(8'd0);
         if (enc_v != 0 && enc_v != 3) content.push_back(8'd0);
         n = $urandom_range(12);
         for (i = 0; i < n; i++) content.push_back(any_byte());
         fsz = content.size();
         body_bytes.push_back("A"); body_bytes.push_back("P");
         body_bytes.push_back("I"); body_bytes.push_back("C");
         for (i = 0; i < 4; i++) body_bytes.push_back(8'd0);
         body_bytes[body_bytes.size() - 1] = {1'b0, fsz[6:0]};
         body_bytes.push_back(8'd0); body_bytes.push_back(8'd0);
         foreach (content[j]) body_bytes.push_back(content[j]);
      end
      n = $urandom_range(4);
      for (i = 0; i < n; i++) body_bytes.push_back(($urandom_range(1)) ? 8'd0 : any_byte());
      // occasional corruption of one body byte
      if (body_bytes.size() != 0 && $urandom_range(7) == 0)
         body_bytes[$urandom_range(body_bytes.size() - 1)] = any_byte();
      body = body_bytes.size();
      if (ext) body += 6;
      if (body == 0) body = 1;
      stream.push_back("I"); stream.push_back("D"); stream.push_back("3");
      stream.push_back(version[7:0]); stream.push_back(any_byte());
      stream.push_back(ext ? 8'h40 | (any_byte() & 8'hbf) : any_byte() & 8'hbf);
      put_synchsafe(body);
      if (ext) begin
         put_size(6, version);
         stream.push_back(any_byte()); stream.push_back(any_byte());
      end
      foreach (body_bytes[j]) stream.push_back(body_bytes[j]);
      // short stream, trailing bytes or exact
      case ($urandom_range(5))
         0: begin
            n = $urandom_range(stream.size() - 1, 1);
            while (stream.size() > n) void'(stream.pop_back());
         end
         1: begin
            n = $urandom_range(5, 1);
            for (i = 0; i < n; i++) stream.push_back(any_byte());
         end
         default: ;
      endcase
      // a little pure noise too
      if ($urandom_range(11) == 0) begin
         stream.delete();
         n = $urandom_range(12, 1);
         for (i = 0; i < n; i++) stream.push_back(any_byte());
      end
   endfunction

   task automatic send_stream();
      foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Directed table: short streams with reports read off at a glance
   // ---------------------------------------------------------------------
   typedef struct {
      logic [7:0] data;
      logic       eos;
      logic       known;
      logic [2:0] status;
   } row_type;

   localparam int ROWS = 25;
   row_type directed[ROWS] = '{
      '{8'h00, 1'b1, 1'b1, id3x_pkg::ST_NOTTAG},   // not magic, one-byte stream
      '{8'hff, 1'b1, 1'b1, id3x_pkg::ST_NOTTAG},
      '{8'h49, 1'b1, 1'b1, id3x_pkg::ST_TRUNC},    // header cut short
      '{8'h49, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h44, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h33, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h05, 1'b1, 1'b1, id3x_pkg::ST_NOTTAG},   // version out of range
      '{8'h49, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h44, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h33, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h03, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b1, 1'b1, id3x_pkg::ST_BADSIZE},  // zero tag size
      '{8'h49, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h44, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h33, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h04, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h00, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h7f, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'h7f, 1'b0, 1'b0, id3x_pkg::ST_FOUND},
      '{8'hff, 1'b1, 1'b1, id3x_pkg::ST_TRUNC}     // size bytes incomplete
   };

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int phase_no, k;
      rearm_parser();
      cap_size = id3x_pkg::DEFAULT_MAX_TAG;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows: typed status where known, predictor throughout
      foreach (directed[i]) begin
         send_byte(directed[i].data, directed[i].eos);
         if (directed[i].known && expected_words.size() != 0 &&
             expected_words[$].status !== directed[i].status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("row %0d: expected status %0d, mirror gives %0d",
                        i, directed[i].status, expected_words[$].status);
         end
      end
      drain_words();

      // random tags across several caps and idling phases
      for (phase_no = 0; phase_no < 8; phase_no++) begin
         case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         case (phase_no)
            1: write_cap(28'd1);
            3: write_cap(28'hfffffff);
            5: write_cap(28'd40);
            7: write_cap(id3x_pkg::DEFAULT_MAX_TAG);
            default: ;
         endcase
         if (phase_no == 2) hold_off_cycles <= 300;  // fill the queue, stall input
         k = bytes_sent;
         while (bytes_sent - k < 200) begin
            build_tag();
            send_stream();
         end
         // sender pauses until every expected word has come
         drain_words();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_words();
      $display("Sent %0d bytes; checked %0d image words and %0d reports over four caps",
               bytes_sent, images_seen, reports_seen);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hard stop on a hang
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/id3x_pkg.sv
hdl/id3x_parser.sv
hdl/id3x_emitter.sv
hdl/id3v2_picture_frame_extractor.sv
test/id3v2_picture_frame_extractor_test.sv
